FILE: sv/gfpr_pkg.sv
// ----------------------------------------------------------------------------
// gfpr_pkg
// Shared types, constants and GF(256) helpers for the polynomial remainder
// block: field tables, multiply, command codes and coefficient status.
// ----------------------------------------------------------------------------
package gfpr_pkg;

  localparam int MAX_PARITY = 32;
  localparam int IDX_W      = $clog2(MAX_PARITY);
  localparam int PC_W       = 6;

  typedef logic [7:0]       gf_t;
  typedef logic [PC_W-1:0]  pcount_t;
  typedef logic [IDX_W-1:0] pidx_t;
  typedef gf_t              gf_tab_t [256];

  localparam logic [8:0] GF_POLY      = 9'h11D;
  localparam pcount_t    PARITY_RESET = 6'd10;
  localparam pcount_t    MAX_P        = PC_W'(MAX_PARITY);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_FEED = 1'b1
  } cmd_t;

  typedef struct packed {
    logic pending;
    logic lead_zero;
  } coef_stat_t;

  function automatic gf_tab_t build_exp();
    gf_tab_t    t;
    logic [8:0] x;
    x = 9'd1;
    for (int i = 0; i < 256; i++) begin
      t[i] = x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

  function automatic gf_tab_t build_inv();
    gf_tab_t e;
    gf_tab_t t;
    e = build_exp();
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'd0;
    end
    for (int i = 0; i < 255; i++) begin
      t[e[i]] = e[(i == 0) ? 0 : 255 - i];
    end
    return t;
  endfunction

  // alpha^e, entry 255 wraps to alpha^0
  localparam gf_tab_t EXP_TAB = build_exp();
  localparam gf_tab_t INV_TAB = build_inv();

  function automatic gf_t gf_mul(input gf_t a, input gf_t b);
    logic [8:0] x;
    gf_t        r;
    x = {1'b0, a};
    r = 8'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        r = r ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/gfpr_coef.sv
// ----------------------------------------------------------------------------
// gfpr_coef
// Generator coefficient store. Keeps the coefficients as field elements and
// derives the monic-normalized taps g[i] / g[P] used by the division register.
// ----------------------------------------------------------------------------
module gfpr_coef
  import gfpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_en,
  input  pcount_t    load_idx,
  input  logic [8:0] load_log,
  input  logic       renorm_req,
  input  pcount_t    p_eff,
  output coef_stat_t stat,
  output gf_t        norm [MAX_PARITY]
);

  gf_t        g_lo_r [MAX_PARITY];
  gf_t        g_top_r;
  gf_t        norm_r [MAX_PARITY];
  logic       pending_r;
  logic       pending_nxt;
  logic       lead_zero_r;
  gf_t        load_val;
  gf_t        lead;
  gf_t        lead_inv;

  // negative log means a zero coefficient
  assign load_val = load_log[8] ? 8'd0 : EXP_TAB[load_log[7:0]];
  assign lead     = (p_eff == MAX_P) ? g_top_r : g_lo_r[p_eff[IDX_W-1:0]];
  assign lead_inv = INV_TAB[lead];

  assign pending_nxt = load_en | renorm_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b1;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      if (load_idx < MAX_P) begin
        g_lo_r[load_idx[IDX_W-1:0]] <= load_val;
      end else if (load_idx == MAX_P) begin
        g_top_r <= load_val;
      end
    end
  end

  // taps are rebuilt in the cycle after any coefficient or degree change
  always_ff @(posedge clk) begin
    if (pending_r) begin
      for (int i = 0; i < MAX_PARITY; i++) begin
        norm_r[i] <= gf_mul(g_lo_r[i], lead_inv);
      end
      lead_zero_r <= (lead == 8'd0);
    end
  end

  assign stat.pending   = pending_r;
  assign stat.lead_zero = lead_zero_r;
  assign norm           = norm_r;

  a_load_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    load_en |=> pending_r)
    else $error("coefficient load did not schedule a tap rebuild");

  a_lead_zero_held: assert property (@(posedge clk) disable iff (!rst_n)
    !pending_r |=> $stable(lead_zero_r))
    else $error("leading-zero flag changed without a tap rebuild");

endmodule

FILE: sv/gfpr_emit.sv
// ----------------------------------------------------------------------------
// gfpr_emit
// Parity output stage. Captures the finished remainder and plays it out one
// byte per transaction, highest degree first, through an output register.
// ----------------------------------------------------------------------------
module gfpr_emit
  import gfpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    snap_en,
  input  gf_t     snap_data [MAX_PARITY],
  input  logic    snap_err,
  input  pcount_t p_eff,
  output logic    busy,
  input  logic    out_tready,
  output logic    out_tvalid,
  output gf_t     out_tdata,
  output logic    out_tlast,
  output logic    out_tuser
);

  gf_t   snap_r [MAX_PARITY];
  logic  err_r;
  logic  busy_r;
  logic  busy_nxt;
  pidx_t idx_r;
  logic  out_valid_r;
  logic  out_valid_nxt;
  gf_t   out_data_r;
  logic  out_last_r;
  logic  out_err_r;
  logic  out_load;

  assign out_load = busy_r && (!out_valid_r || out_tready);

  always_comb begin
    busy_nxt = busy_r;
    if (snap_en) begin
      busy_nxt = 1'b1;
    end else if (out_load && idx_r == '0) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_en) begin
      snap_r <= snap_data;
      err_r  <= snap_err;
      idx_r  <= IDX_W'(p_eff - 6'd1);
    end else if (out_load) begin
      idx_r <= idx_r - 1'b1;
    end
    if (out_load) begin
      out_data_r <= err_r ? 8'd0 : snap_r[idx_r];
      out_last_r <= (idx_r == '0);
      out_err_r  <= err_r;
    end
  end

  assign busy       = busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  a_no_snap_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    snap_en |-> !busy_r)
    else $error("remainder captured while a parity run is still in flight");

  a_err_bytes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_data_r == 8'd0)
    else $error("parity byte nonzero on a generator error run");

endmodule

FILE: sv/gf256_polynomial_remainder.sv
// ----------------------------------------------------------------------------
// gf256_polynomial_remainder
// Reed-Solomon style parity generator over GF(256), polynomial 0x11D.
// ----------------------------------------------------------------------------
// Usage: set the generator degree P on the cfg port (while idle), load the
// generator log coefficients g[0..P] with load transactions on the input
// stream (tuser = 0), then stream message bytes (tuser = 1) highest degree
// first, tlast on the final byte. After the final byte the output stream
// carries P parity bytes, highest degree first, tlast on the last one and
// tuser set on every byte if g[P] is zero (the bytes are then zero).
// Flow: an accepted item is held in the input register; once the last
// message byte executes, the remainder is captured into the output stage,
// which then loads the first parity byte into its output register.
// Throughput: one item per cycle while nothing stalls, limited by the
// division register update. A message byte right after a coefficient load
// or a cfg write waits while the normalized taps are rebuilt. A final byte
// waits while the previous run is still emitting.
// Reset: degree 10, remainder cleared, no output pending; generator
// coefficients hold no value until loaded. A stalled output holds its byte
// while input bytes keep flowing into the next message.
// ----------------------------------------------------------------------------
module gf256_polynomial_remainder
  import gfpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // tdata: [5:0] coeff_index, [14:6] generator_log_value, [22:15] message_byte,
  //        [23] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,   // command
  input  logic        in_tlast,   // message_last
  // tdata: [7:0] parity_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,  // parity_last
  output logic        out_tuser,  // generator_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data    // parity_count
);

  logic       in_vld_r;
  logic       in_vld_nxt;
  cmd_t       cmd_r;
  pcount_t    cidx_r;
  logic [8:0] log_r;
  gf_t        byte_r;
  logic       last_r;

  pcount_t    p_r;
  pcount_t    p_nxt;
  gf_t        rem_r   [MAX_PARITY];
  gf_t        rem_nxt [MAX_PARITY];
  gf_t        rem_upd [MAX_PARITY];
  gf_t        rem_new [MAX_PARITY];
  gf_t        fb;

  coef_stat_t coef_stat;
  gf_t        norm [MAX_PARITY];
  logic       emit_busy;

  logic       in_accept;
  logic       is_feed;
  logic       feed_ok;
  logic       exec_fire;
  logic       feed_fire;
  logic       load_en;
  logic       snap_en;
  logic       cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  assign is_feed   = (cmd_r == CMD_FEED);
  assign feed_ok   = !coef_stat.pending && (!last_r || !emit_busy);
  assign exec_fire = in_vld_r && (!is_feed || feed_ok);
  assign feed_fire = exec_fire && is_feed;
  assign load_en   = exec_fire && !is_feed;
  assign snap_en   = feed_fire && last_r;
  assign in_tready = !in_vld_r || exec_fire;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (exec_fire) begin
      in_vld_nxt = 1'b0;
    end
    // degree out of range is clamped to 1..MAX_PARITY
    p_nxt = p_r;
    if (cfg_fire) begin
      if (cfg_data == '0) begin
        p_nxt = 6'd1;
      end else if (cfg_data > MAX_P) begin
        p_nxt = MAX_P;
      end else begin
        p_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= cmd_t'(in_tuser);
      cidx_r <= in_tdata[5:0];
      log_r  <= in_tdata[14:6];
      byte_r <= in_tdata[22:15];
      last_r <= in_tlast;
    end
  end

  // division register: all cells below P update at once per message byte
  assign fb = byte_r ^ rem_r[IDX_W'(p_r - 6'd1)];

  always_comb begin
    for (int i = 0; i < MAX_PARITY; i++) begin
      if (PC_W'(i) < p_r) begin
        rem_upd[i] = ((i == 0) ? 8'd0 : rem_r[(i == 0) ? 0 : i - 1]) ^ gf_mul(fb, norm[i]);
      end else begin
        rem_upd[i] = rem_r[i];
      end
      rem_new[i] = (feed_fire && !coef_stat.lead_zero) ? rem_upd[i] : rem_r[i];
      rem_nxt[i] = (cfg_fire || snap_en) ? 8'd0 : rem_new[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      p_r      <= PARITY_RESET;
      for (int i = 0; i < MAX_PARITY; i++) begin
        rem_r[i] <= 8'd0;
      end
    end else begin
      in_vld_r <= in_vld_nxt;
      p_r      <= p_nxt;
      rem_r    <= rem_nxt;
    end
  end

  gfpr_coef u_coef (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_en    (load_en),
    .load_idx   (cidx_r),
    .load_log   (log_r),
    .renorm_req (cfg_fire),
    .p_eff      (p_r),
    .stat       (coef_stat),
    .norm       (norm)
  );

  gfpr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_en    (snap_en),
    .snap_data  (rem_new),
    .snap_err   (coef_stat.lead_zero),
    .p_eff      (p_r),
    .busy       (emit_busy),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_feed_taps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    feed_fire |-> !coef_stat.pending)
    else $error("message byte processed with stale generator taps");

  a_cfg_renorm: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> coef_stat.pending && p_r >= 6'd1 && p_r <= MAX_P)
    else $error("degree write did not rebuild taps or left degree out of range");

endmodule
